@@ hdl/ssit_pkg.sv @@
// types and constants for the speed series interning table
`default_nettype none
package ssit_pkg;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_INTERN = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_MANY    = 3'd1,
        ST_ORDER       = 3'd2,
        ST_SERIES_FULL = 3'd3,
        ST_LINES_FULL  = 3'd4,
        ST_NOT_FOUND   = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] line_id;
        logic        reverse_dir;
        logic [11:0] slot_time;
        logic [7:0]  slot_speed;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] series_ref;
        logic       created;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,
        S_SER_RD,
        S_SER_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_DECIDE,
        S_COPY,
        S_BIND,
        S_LK_RD,
        S_LK_CHK,
        S_DONE
    } t_state;

    localparam int SLOT_W = 20;

endpackage
`default_nettype wire

@@ hdl/speed_series_interning_table_core.sv @@
// top level: sequencer around the series, slot and line memories
//
// One item is taken at a time. Start passes through the done state to its
// result, append through the append and done states. Intern walks the
// stored series in order; for each whose length matches it compares slot
// by slot through the slot memory, and if none matches it copies the
// current series slot by slot into the store.
// Lookup walks the line memory, one recorded binding at a time. All
// memories have one registered read port; no clearing pass is needed since
// fill counts mark the valid region. The result sits in an output register
// and the next item is taken from the cycle after it has been transferred.
`default_nettype none
module speed_series_interning_table_core #(
    parameter int MAX_SLOTS    = 48,
    parameter int SERIES_DEPTH = 1024,
    parameter int SLOT_DEPTH   = 8192,
    parameter int LINE_DEPTH   = 4096
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  ssit_pkg::t_in_item     i_data,
    output logic                   o_valid,
    input  wire                    i_ready,
    output ssit_pkg::t_out_item    o_data
);
    import ssit_pkg::*;

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int CA = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SW = $clog2(SERIES_DEPTH + 1);
    localparam int SA = $clog2(SERIES_DEPTH);
    localparam int PW = $clog2(SLOT_DEPTH + 1);
    localparam int PA = $clog2(SLOT_DEPTH);
    localparam int LW = $clog2(LINE_DEPTH + 1);
    localparam int LA = $clog2(LINE_DEPTH);

    // memories
    logic [SLOT_W-1:0] m_cur [MAX_SLOTS];
    logic [SLOT_W-1:0] m_slot [SLOT_DEPTH];
    logic [PA+CW-1:0]  m_ser [SERIES_DEPTH];
    logic [32:0]       m_key [LINE_DEPTH];
    logic [9:0]        m_ref [LINE_DEPTH];

    t_state r_state, n_state;
    t_in_item r_in;
    logic [CW-1:0] r_len;
    logic [SW-1:0] r_ser_used;
    logic [PW-1:0] r_slots_used;
    logic [LW-1:0] r_lines_used;
    logic [SW-1:0] r_si;
    logic [CW-1:0] r_ci;
    logic [LW-1:0] r_li;
    logic          r_found;
    logic [9:0]    r_ref;
    logic [SLOT_W-1:0] r_last;
    t_out_item     r_out;
    logic          r_ovalid;

    // read data registers
    logic [SLOT_W-1:0] r_cur_q, r_slot_q;
    logic [PA+CW-1:0]  r_ser_q;
    logic [32:0]       r_key_q;
    logic [9:0]        r_ref_q;

    // read addresses and write strobes
    logic [CA-1:0] cur_ra;
    logic [PA-1:0] slot_ra;
    logic cur_we, slot_we, ser_we, line_we;
    logic [CA-1:0] cur_wa;
    logic [SLOT_W-1:0] cur_wd;

    logic [PA-1:0] ser_base;
    logic [CW-1:0] ser_len;
    logic [PW:0]   slot_end;
    logic [PW-1:0] copy_pos;

    assign ser_base = r_ser_q[PA+CW-1:CW];
    assign ser_len  = r_ser_q[CW-1:0];
    assign slot_end = {1'b0, r_slots_used} + (PW+1)'(r_len);
    assign copy_pos = r_slots_used + PW'(r_ci);

    always_ff @(posedge i_clk) begin
        r_cur_q <= m_cur[cur_ra];
        r_slot_q <= m_slot[slot_ra];
        r_ser_q <= m_ser[r_si[SA-1:0]];
        r_key_q <= m_key[r_li[LA-1:0]];
        r_ref_q <= m_ref[r_li[LA-1:0]];
        if (cur_we) m_cur[cur_wa] <= cur_wd;
        if (slot_we) m_slot[copy_pos[PA-1:0]] <= r_cur_q;
        if (ser_we) m_ser[r_ser_used[SA-1:0]] <= {r_slots_used[PA-1:0], r_len};
        if (line_we) begin
            m_key[r_lines_used[LA-1:0]] <= {r_in.line_id, r_in.reverse_dir};
            m_ref[r_lines_used[LA-1:0]] <= r_ref;
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                case (t_op'(i_data.op))
                    OP_START:  n_state = S_DONE;
                    OP_APPEND: n_state = S_APPEND;
                    OP_INTERN: n_state = S_SER_RD;
                    default:   n_state = S_LK_RD;
                endcase
            end
            S_APPEND: n_state = S_DONE;
            S_SER_RD: n_state = (r_si >= r_ser_used) ? S_DECIDE : S_SER_CHK;
            S_SER_CHK: n_state = (ser_len == r_len) ? S_CMP_RD : S_SER_RD;
            S_CMP_RD: begin
                if (r_ci == r_len) n_state = S_DECIDE;
                else if ({1'b0, ser_base} + (PA+1)'(r_ci) >= (PA+1)'(SLOT_DEPTH))
                    n_state = S_SER_RD;
                else n_state = S_CMP_CHK;
            end
            S_CMP_CHK: n_state = (r_slot_q == r_cur_q) ? S_CMP_RD : S_SER_RD;
            S_DECIDE: begin
                if (!r_found && (r_ser_used >= SW'(SERIES_DEPTH)
                                 || slot_end > (PW+1)'(SLOT_DEPTH)))
                    n_state = S_DONE;
                else if (r_lines_used >= LW'(LINE_DEPTH)) n_state = S_DONE;
                else if (!r_found) n_state = S_COPY;
                else n_state = S_BIND;
            end
            S_COPY: n_state = (r_ci == r_len) ? S_BIND : S_COPY;
            S_BIND: n_state = S_DONE;
            S_LK_RD: n_state = (r_li >= r_lines_used) ? S_DONE : S_LK_CHK;
            S_LK_CHK: n_state = (r_key_q == {r_in.line_id, r_in.reverse_dir})
                                ? S_DONE : S_LK_RD;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        cur_ra  = CA'(0);
        slot_ra = ser_base + PA'(r_ci);
        cur_we  = 1'b0;
        cur_wa  = r_len[CA-1:0];
        cur_wd  = {r_in.slot_time, r_in.slot_speed};
        slot_we = 1'b0;
        ser_we  = 1'b0;
        line_we = 1'b0;
        case (r_state)
            S_IDLE: cur_ra = (r_len == 0) ? CA'(0) : CA'(r_len - CW'(1));
            S_CMP_RD, S_COPY: cur_ra = r_ci[CA-1:0];
            S_DECIDE: cur_ra = CA'(0);
            default: ;
        endcase
        if (r_state == S_APPEND && r_len < CW'(MAX_SLOTS)) begin
            if (r_len == 0) begin
                cur_we = 1'b1;
                cur_wd = {12'd0, r_in.slot_speed};
            end else if (r_last[19:8] < r_in.slot_time
                         && r_last[7:0] != r_in.slot_speed) begin
                cur_we = 1'b1;
            end
        end
        if (r_state == S_COPY && r_ci != r_len) begin
            slot_we = 1'b1;
            cur_ra = CA'(r_ci + CW'(1));
        end
        if (r_state == S_COPY && r_ci == r_len) ser_we = 1'b1;
        if (r_state == S_BIND) line_we = 1'b1;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len <= '0;
            r_ser_used <= '0;
            r_slots_used <= '0;
            r_lines_used <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_in <= i_data;
                    r_si <= '0;
                    r_li <= '0;
                    r_ci <= '0;
                    r_found <= 1'b0;
                    r_ref <= '0;
                    r_out <= '{status: ST_OK, series_ref: 10'd0, created: 1'b0};
                    if (t_op'(i_data.op) == OP_START) r_len <= '0;
                end
                S_APPEND: begin
                    if (r_len >= CW'(MAX_SLOTS)) r_out.status <= ST_TOO_MANY;
                    else if (r_len != 0 && r_last[19:8] >= r_in.slot_time)
                        r_out.status <= ST_ORDER;
                    else if (cur_we) r_len <= r_len + CW'(1);
                end
                S_SER_RD: r_ci <= '0;
                S_SER_CHK: if (ser_len != r_len) r_si <= r_si + SW'(1);
                S_CMP_RD: begin
                    if (r_ci == r_len) begin
                        r_found <= 1'b1;
                        r_ref <= 10'(r_si);
                    end else if ({1'b0, ser_base} + (PA+1)'(r_ci) >= (PA+1)'(SLOT_DEPTH))
                        r_si <= r_si + SW'(1);
                end
                S_CMP_CHK: begin
                    if (r_slot_q == r_cur_q) r_ci <= r_ci + CW'(1);
                    else r_si <= r_si + SW'(1);
                end
                S_DECIDE: begin
                    r_ci <= '0;
                    if (!r_found && (r_ser_used >= SW'(SERIES_DEPTH)
                                     || slot_end > (PW+1)'(SLOT_DEPTH)))
                        r_out.status <= ST_SERIES_FULL;
                    else if (r_lines_used >= LW'(LINE_DEPTH))
                        r_out.status <= ST_LINES_FULL;
                    else if (!r_found) r_ref <= 10'(r_ser_used);
                end
                S_COPY: begin
                    if (r_ci == r_len) begin
                        r_slots_used <= PW'(slot_end);
                        r_ser_used <= r_ser_used + SW'(1);
                        r_out.created <= 1'b1;
                    end else r_ci <= r_ci + CW'(1);
                end
                S_BIND: begin
                    r_lines_used <= r_lines_used + LW'(1);
                    r_out.series_ref <= r_ref;
                end
                S_LK_RD: if (r_li >= r_lines_used) r_out.status <= ST_NOT_FOUND;
                S_LK_CHK: begin
                    if (r_key_q == {r_in.line_id, r_in.reverse_dir})
                        r_out.series_ref <= r_ref_q;
                    else r_li <= r_li + LW'(1);
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
            // last slot tracks the read issued while idle
            if (r_state == S_IDLE) r_last <= r_cur_q;
        end
    end

endmodule
`default_nettype wire
